>>> sv/scc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sliding complex correlator.
// No dependencies; every other file refers to this package by scoped names.
package scc_pkg;

    localparam int TAP_BITS      = 16;
    localparam int ACC_BITS      = 40;
    localparam int MAG_BITS      = 39;
    localparam int CNT_BITS      = 21;
    localparam int OIDX_BITS     = 20;
    localparam int LEN_BITS      = 8;
    localparam int BLEN_BITS     = 20;
    localparam int STEP_BITS     = 8;
    localparam int TIDX_BITS     = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE    = 2'd2;

    // input item kinds
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
    } cplx_acc_t;

endpackage

>>> sv/scc_in_if.sv
`timescale 1ns / 1ps
// Input request channel of the correlator: tap loads and samples.
// Depends on scc_pkg for the fixed field widths.
interface scc_in_if #(parameter int SAMPLE_BITS = 16);
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [scc_pkg::TIDX_BITS-1:0]       tap_index;
    logic signed [scc_pkg::TAP_BITS-1:0] tap_real;
    logic signed [scc_pkg::TAP_BITS-1:0] tap_imag;
    logic signed [SAMPLE_BITS-1:0]       sample_real;
    logic signed [SAMPLE_BITS-1:0]       sample_imag;
    logic                                block_start;

    modport source (output valid, action, tap_index, tap_real, tap_imag,
                    sample_real, sample_imag, block_start, input ready);
    modport sink (input valid, action, tap_index, tap_real, tap_imag,
                  sample_real, sample_imag, block_start, output ready);
endinterface

>>> sv/scc_out_if.sv
`timescale 1ns / 1ps
// Result request channel of the correlator.
// Depends on scc_pkg for the field widths.
interface scc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [scc_pkg::ACC_BITS-1:0] corr_real;
    logic signed [scc_pkg::ACC_BITS-1:0] corr_imag;
    logic [scc_pkg::MAG_BITS-1:0]        corr_magnitude;
    logic [scc_pkg::OIDX_BITS-1:0]       window_index;

    modport source (output valid, corr_real, corr_imag, corr_magnitude,
                    window_index, input ready);
    modport sink (input valid, corr_real, corr_imag, corr_magnitude,
                  window_index, output ready);
endinterface

>>> sv/scc_cell.sv
`timescale 1ns / 1ps
// One correlator cell: holds one history sample and one reference tap.
// Depends on scc_pkg.
module scc_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hist_en,
    input  logic signed [SAMPLE_BITS-1:0]       hist_in_re,
    input  logic signed [SAMPLE_BITS-1:0]       hist_in_im,
    output logic signed [SAMPLE_BITS-1:0]       hist_re,
    output logic signed [SAMPLE_BITS-1:0]       hist_im,
    input  logic                                tap_we,
    input  logic signed [scc_pkg::TAP_BITS-1:0] tap_wr_re,
    input  logic signed [scc_pkg::TAP_BITS-1:0] tap_wr_im,
    input  logic                                tap_rot,
    input  logic signed [scc_pkg::TAP_BITS-1:0] tap_in_re,
    input  logic signed [scc_pkg::TAP_BITS-1:0] tap_in_im,
    output logic signed [scc_pkg::TAP_BITS-1:0] tap_re,
    output logic signed [scc_pkg::TAP_BITS-1:0] tap_im
);
    logic signed [SAMPLE_BITS-1:0]       hist_re_reg;
    logic signed [SAMPLE_BITS-1:0]       hist_im_reg;
    logic signed [scc_pkg::TAP_BITS-1:0] tap_re_reg;
    logic signed [scc_pkg::TAP_BITS-1:0] tap_im_reg;

    // take a direct write, or the neighbor's tap while the row rotates
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_re_reg <= tap_wr_re;
            tap_im_reg <= tap_wr_im;
        end
        else if (tap_rot)
        begin
            tap_re_reg <= tap_in_re;
            tap_im_reg <= tap_in_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_re_reg <= '0;
            hist_im_reg <= '0;
        end
        else if (hist_en)
        begin
            hist_re_reg <= hist_in_re;
            hist_im_reg <= hist_in_im;
        end
    end

    assign hist_re = hist_re_reg;
    assign hist_im = hist_im_reg;
    assign tap_re  = tap_re_reg;
    assign tap_im  = tap_im_reg;
endmodule

>>> sv/scc_mag.sv
`timescale 1ns / 1ps
// Magnitude unit: squares on a shared 20x20 multiplier, then a digit-by-digit
// integer square root, two radicand bits per cycle. Depends on scc_pkg.
module scc_mag (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  scc_pkg::cplx_acc_t           value,
    output logic                         done,
    output logic [scc_pkg::MAG_BITS-1:0] magnitude
);
    localparam int AW = scc_pkg::ACC_BITS;
    localparam int HW = AW / 2;
    localparam int RW = 2 * AW;
    localparam int SQ_STEPS = 6;
    localparam int RT_STEPS = AW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_RT   = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [1:0] SH_HH = 2'd0;
    localparam logic [1:0] SH_HL = 2'd1;
    localparam logic [1:0] SH_LL = 2'd2;

    logic [1:0]      st_reg, st_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [AW-1:0]   a_reg, b_reg;
    logic [RW-1:0]   rad_reg, rad_next;
    logic [AW:0]     rem_reg, rem_next;
    logic [AW-1:0]   root_reg, root_next;
    logic [HW-1:0]   ma, mb;
    logic [1:0]      sh;
    logic [AW-1:0]   prod;
    logic [RW-1:0]   term;
    logic [AW+2:0]   rem_t, trial;

    always_comb
    begin
        ma = a_reg[AW-1:HW];
        mb = a_reg[AW-1:HW];
        sh = SH_HH;
        unique case (cnt_reg)
            6'd0: begin ma = a_reg[AW-1:HW]; mb = a_reg[AW-1:HW]; sh = SH_HH; end
            6'd1: begin ma = a_reg[AW-1:HW]; mb = a_reg[HW-1:0];  sh = SH_HL; end
            6'd2: begin ma = a_reg[HW-1:0];  mb = a_reg[HW-1:0];  sh = SH_LL; end
            6'd3: begin ma = b_reg[AW-1:HW]; mb = b_reg[AW-1:HW]; sh = SH_HH; end
            6'd4: begin ma = b_reg[AW-1:HW]; mb = b_reg[HW-1:0];  sh = SH_HL; end
            6'd5: begin ma = b_reg[HW-1:0];  mb = b_reg[HW-1:0];  sh = SH_LL; end
            default: begin ma = '0; mb = '0; sh = SH_LL; end
        endcase
        prod = AW'(ma) * AW'(mb);
        unique case (sh)
            SH_HH:   term = RW'(prod) << AW;
            SH_HL:   term = RW'(prod) << (HW + 1);
            default: term = RW'(prod);
        endcase

        rem_t = {rem_reg, rad_reg[RW-1:RW-2]};
        trial = {1'b0, root_reg, 2'b01};

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    st_next   = ST_SQ;
                    cnt_next  = '0;
                    rad_next  = '0;
                    rem_next  = '0;
                    root_next = '0;
                end
            end
            ST_SQ:
            begin
                rad_next = rad_reg + term;
                if (cnt_reg == 6'(SQ_STEPS - 1))
                begin
                    cnt_next = '0;
                    st_next  = ST_RT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_RT:
            begin
                rad_next = rad_reg << 2;
                if (rem_t >= trial)
                begin
                    rem_next  = (AW + 1)'(rem_t - trial);
                    root_next = {root_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[AW:0];
                    root_next = {root_reg[AW-2:0], 1'b0};
                end
                if (cnt_reg == 6'(RT_STEPS - 1))
                    st_next = ST_DONE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            // hold absolute values; the most negative code maps to 2^39
            a_reg <= value.re[AW-1] ? AW'(-value.re) : AW'(value.re);
            b_reg <= value.im[AW-1] ? AW'(-value.im) : AW'(value.im);
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done      = (st_reg == ST_DONE);
    assign magnitude = root_reg[AW-1] ? '1 : root_reg[scc_pkg::MAG_BITS-1:0];
endmodule

>>> sv/sliding_complex_correlator_unit.sv
`timescale 1ns / 1ps
// Sliding complex correlator, top level. Tap loads and non-reporting samples
// do not hold the input, so while idle it runs at one item per cycle. A sample that
// closes a reported window holds the input while history and taps rotate a full
// turn, one tap per cycle, then through six squaring steps and 40 square-root
// steps; a waiting result holds it longer. Reset clears history, counters and
// control state and loads default settings; taps stay undefined until loaded.
module sliding_complex_correlator_unit #(
    parameter int MAX_TAPS    = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [scc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [scc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    scc_in_if.sink                                din,
    scc_out_if.source                             dout
);
    localparam int LW = $clog2(MAX_TAPS + 1);
    localparam int CW = scc_pkg::CNT_BITS + 1;
    localparam int KW = $clog2(2 * MAX_TAPS);
    localparam int PW = SAMPLE_BITS + scc_pkg::TAP_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_CAPT = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    // configuration registers
    logic [scc_pkg::LEN_BITS-1:0]  ref_length_reg;
    logic [scc_pkg::BLEN_BITS-1:0] block_length_reg;
    logic [scc_pkg::STEP_BITS-1:0] step_size_reg;

    // block position counters
    logic [scc_pkg::CNT_BITS-1:0]  sample_cnt_reg, sample_cnt_next;
    logic [scc_pkg::STEP_BITS-1:0] phase_reg, phase_next;
    logic [scc_pkg::OIDX_BITS-1:0] out_cnt_reg, out_cnt_next;

    logic [2:0] state_reg, state_next;

    logic                          accept, take_sample, take_load, emit;
    logic [LW-1:0]                 len_eff;
    logic [scc_pkg::STEP_BITS-1:0] step_eff;
    logic [scc_pkg::CNT_BITS-1:0]  sc_eff;
    logic [scc_pkg::STEP_BITS-1:0] ph_eff, ph_w;
    logic [scc_pkg::OIDX_BITS-1:0] oc_eff;
    logic [CW-1:0]                 sc1, len_c, kpos, bl1, lim;

    // cell row: history samples and taps
    logic signed [SAMPLE_BITS-1:0]       h_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]       h_im [MAX_TAPS];
    logic signed [scc_pkg::TAP_BITS-1:0] t_re [MAX_TAPS];
    logic signed [scc_pkg::TAP_BITS-1:0] t_im [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]       head_re, head_im;

    // window sum sequencing
    logic                 mac_busy, hist_rot, tap_rot, acc_en, hist_en;
    logic [KW-1:0]        cyc_reg, cyc_next;
    logic [KW-1:0]        pre_cnt, mac_last;
    logic signed [PW-1:0] p_re, p_im;
    scc_pkg::cplx_acc_t   acc_reg, acc_next;

    logic [scc_pkg::OIDX_BITS-1:0] widx_reg;
    logic                          mag_done;
    logic [scc_pkg::MAG_BITS-1:0]  mag_value;

    // result register facing the output channel
    logic                                 out_valid_reg;
    logic signed [scc_pkg::ACC_BITS-1:0]  out_re_reg, out_im_reg;
    logic [scc_pkg::MAG_BITS-1:0]         out_mag_reg;
    logic [scc_pkg::OIDX_BITS-1:0]        out_idx_reg;
    logic                                 out_load;

    assign din.ready   = (state_reg == S_IDLE);
    assign accept      = din.valid && din.ready;
    assign take_sample = accept && (din.action == scc_pkg::ACT_PROCESS);
    assign take_load   = accept && (din.action == scc_pkg::ACT_LOAD);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_length_reg   <= scc_pkg::LEN_BITS'(1);
            block_length_reg <= '0;
            step_size_reg    <= scc_pkg::STEP_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scc_pkg::REG_REF_LENGTH:
                    ref_length_reg <= cfg_data[scc_pkg::LEN_BITS-1:0];
                scc_pkg::REG_BLOCK_LENGTH:
                    block_length_reg <= cfg_data[scc_pkg::BLEN_BITS-1:0];
                scc_pkg::REG_STEP_SIZE:
                    step_size_reg <= cfg_data[scc_pkg::STEP_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Window bookkeeping: clamp length and step, restart on block_start, and
    // decide whether the window closing with this sample is reported.
    always_comb
    begin
        if (ref_length_reg == '0)
            len_eff = LW'(1);
        else if (int'(ref_length_reg) > MAX_TAPS)
            len_eff = LW'(MAX_TAPS);
        else
            len_eff = LW'(ref_length_reg);
        step_eff = (step_size_reg == '0) ? scc_pkg::STEP_BITS'(1) : step_size_reg;

        sc_eff = din.block_start ? '0 : sample_cnt_reg;
        ph_eff = din.block_start ? '0 : phase_reg;
        oc_eff = din.block_start ? '0 : out_cnt_reg;

        sc1   = CW'(sc_eff) + CW'(1);
        len_c = CW'(len_eff);
        kpos  = sc1 - len_c;
        bl1   = CW'(block_length_reg) + CW'(1);
        lim   = bl1 - len_c;

        emit       = 1'b0;
        phase_next = ph_eff;
        ph_w       = ph_eff;
        if (sc1 >= len_c)
        begin
            // drop a phase left over from a larger step
            ph_w = (ph_eff >= step_eff) ? '0 : ph_eff;
            emit = (ph_w == '0) && (bl1 >= len_c) && (kpos + CW'(step_eff) <= lim);
            phase_next = (ph_w + 1'b1 >= step_eff) ? '0 : ph_w + 1'b1;
        end

        sample_cnt_next = (&sc_eff) ? sc_eff : sc_eff + 1'b1;
        out_cnt_next    = emit ? oc_eff + 1'b1 : oc_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            phase_reg      <= '0;
            out_cnt_reg    <= '0;
        end
        else if (take_sample)
        begin
            sample_cnt_reg <= sample_cnt_next;
            phase_reg      <= phase_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    // Window sum schedule. The history rotates up a full turn and is read at the
    // last cell; the taps rotate down a full turn, starting once the window's first
    // sample has reached the last cell, and are read at cell 0. In the overlap the
    // pairs line up as sample k+j with tap j; both rows end where they began.
    assign mac_busy = (state_reg == S_MAC);
    assign pre_cnt  = KW'(MAX_TAPS) - KW'(len_eff);
    assign mac_last = pre_cnt + KW'(MAX_TAPS - 1);
    assign hist_rot = (cyc_reg < KW'(MAX_TAPS));
    assign tap_rot  = mac_busy && (cyc_reg >= pre_cnt);
    assign acc_en   = (cyc_reg >= pre_cnt) && hist_rot;
    assign hist_en  = take_sample || (mac_busy && hist_rot);

    // new samples enter at cell 0; during the sum the last cell wraps around
    assign head_re = mac_busy ? h_re[MAX_TAPS-1] : din.sample_real;
    assign head_im = mac_busy ? h_im[MAX_TAPS-1] : din.sample_imag;

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0]       hin_re, hin_im;
        logic signed [scc_pkg::TAP_BITS-1:0] tin_re, tin_im;
        if (i == 0)
        begin : g_first
            assign hin_re = head_re;
            assign hin_im = head_im;
        end
        else
        begin : g_rest
            assign hin_re = h_re[i-1];
            assign hin_im = h_im[i-1];
        end
        if (i == MAX_TAPS - 1)
        begin : g_last
            assign tin_re = t_re[0];
            assign tin_im = t_im[0];
        end
        else
        begin : g_mid
            assign tin_re = t_re[i+1];
            assign tin_im = t_im[i+1];
        end

        scc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .hist_en    (hist_en),
            .hist_in_re (hin_re),
            .hist_in_im (hin_im),
            .hist_re    (h_re[i]),
            .hist_im    (h_im[i]),
            .tap_we     (take_load && (int'(din.tap_index) == i)),
            .tap_wr_re  (din.tap_real),
            .tap_wr_im  (din.tap_imag),
            .tap_rot    (tap_rot),
            .tap_in_re  (tin_re),
            .tap_in_im  (tin_im),
            .tap_re     (t_re[i]),
            .tap_im     (t_im[i])
        );
    end

    // sample times conjugated tap, added to the running sum
    always_comb
    begin
        p_re = PW'(h_re[MAX_TAPS-1]) * PW'(t_re[0]) + PW'(h_im[MAX_TAPS-1]) * PW'(t_im[0]);
        p_im = PW'(h_im[MAX_TAPS-1]) * PW'(t_re[0]) - PW'(h_re[MAX_TAPS-1]) * PW'(t_im[0]);
        acc_next.re = acc_reg.re + scc_pkg::ACC_BITS'(p_re);
        acc_next.im = acc_reg.im + scc_pkg::ACC_BITS'(p_im);
    end

    scc_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_CAPT),
        .value     (acc_reg),
        .done      (mag_done),
        .magnitude (mag_value)
    );

    // sequencer: sum the window, run the magnitude, hand off the result
    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || dout.ready);

    always_comb
    begin
        state_next = state_reg;
        cyc_next   = cyc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_sample && emit)
                begin
                    state_next = S_MAC;
                    cyc_next   = '0;
                end
            end
            S_MAC:
            begin
                if (cyc_reg == mac_last)
                    state_next = S_CAPT;
                else
                    cyc_next = cyc_reg + 1'b1;
            end
            S_CAPT: state_next = S_CALC;
            S_CALC: if (mag_done) state_next = S_HOLD;
            S_HOLD: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cyc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cyc_reg   <= cyc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample && emit)
        begin
            widx_reg <= oc_eff;
            acc_reg  <= '0;
        end
        else if (mac_busy && acc_en)
            acc_reg <= acc_next;
        if (out_load)
        begin
            out_re_reg  <= acc_reg.re;
            out_im_reg  <= acc_reg.im;
            out_mag_reg <= mag_value;
            out_idx_reg <= widx_reg;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.corr_real      = out_re_reg;
    assign dout.corr_imag      = out_im_reg;
    assign dout.corr_magnitude = out_mag_reg;
    assign dout.window_index   = out_idx_reg;
endmodule
